FILE: sv/ccq_pkg.sv
// package for the coalescing command queue: request and result structs,
// opcode, result kind and event state codes, default sizes. no dependencies
`default_nettype none
package ccq_pkg;

  localparam int QueueDepthDef  = 64;
  localparam int EventDepthDef  = 64;
  localparam int MaxCmdBytesDef = 4096;

  localparam logic [2:0] OP_PUSH    = 3'd0;
  localparam logic [2:0] OP_PENDING = 3'd1;
  localparam logic [2:0] OP_POP     = 3'd2;
  localparam logic [2:0] OP_REPORT  = 3'd3;
  localparam logic [2:0] OP_DRAIN   = 3'd4;

  localparam logic [2:0] K_PUSH     = 3'd0;
  localparam logic [2:0] K_PENDING  = 3'd1;
  localparam logic [2:0] K_COMMAND  = 3'd2;
  localparam logic [2:0] K_EMPTY    = 3'd3;
  localparam logic [2:0] K_ACK      = 3'd4;
  localparam logic [2:0] K_EVENT    = 3'd5;
  localparam logic [2:0] K_NOEVENTS = 3'd6;

  localparam logic [1:0] ST_RECEIVED = 2'd0;
  localparam logic [1:0] ST_DONE     = 2'd1;
  localparam logic [1:0] ST_ERROR    = 2'd2;

  typedef struct packed {
    logic [2:0]         op;
    logic [63:0]        payload;
    logic [15:0]        msg_size;
    logic [31:0]        merge_key;
    logic [31:0]        query_ticket;
    logic [1:0]         run_status;
    logic signed [31:0] echo_serial;
  } req_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [31:0]        ticket_out;
    logic               is_pending;
    logic [63:0]        payload_out;
    logic [15:0]        size_out;
    logic signed [31:0] serial_out;
    logic [1:0]         event_state;
    logic               last;
  } res_t;

endpackage
`default_nettype wire

FILE: sv/coalescing_command_queue.sv
// coalescing command queue top level: slot memory, event log memory and
// the sequencer that scans, updates and drains them. depends on ccq_pkg
//
//   channel   signals                 direction  handshake
//   request   start, busy, req        in         taken when start && !busy
//   result    res_valid, res          out        one cycle strobe, no stall
//
// a push with a key scans queued keys one slot per cycle, then commits an
// append or a merge; a pending query scans the same way. a pop and a logged
// report pass through the event log states before replying.
// a single result shows as busy drops. a drain streams one event per cycle.
// reset clears control only; the memories need no clearing pass.
// the receiver cannot stall: each result is shown for one cycle.
`default_nettype none
module coalescing_command_queue
  import ccq_pkg::*;
#(
  parameter int QUEUE_DEPTH   = QueueDepthDef,
  parameter int EVENT_DEPTH   = EventDepthDef,
  parameter int MAX_CMD_BYTES = MaxCmdBytesDef
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire req_t req,
  output logic      busy,
  output logic      res_valid,
  output res_t      res
);

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int EW = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
  localparam int IW = ((QW > EW) ? QW : EW) + 1;
  localparam logic [QW:0] QFULL = (QW+1)'(QUEUE_DEPTH);
  localparam logic [EW:0] EFULL = (EW+1)'(EVENT_DEPTH);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCAN  = 8'b0000_0010,
    S_CHECK = 8'b0000_0100,
    S_LOG1  = 8'b0000_1000,
    S_LOG2  = 8'b0001_0000,
    S_REPLY = 8'b0010_0000,
    S_DRAIN = 8'b0100_0000,
    S_DOUT  = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic [63:0] payload;
    logic [15:0] size;
    logic [31:0] ticket;
    logic [31:0] key;
  } slot_t;

  typedef struct packed {
    logic [31:0] ticket;
    logic [1:0]  st;
  } ev_t;

  // wrap a sum below twice the depth back into the ring
  function automatic logic [QW-1:0] qwrap(input logic [31:0] s);
    logic [31:0] w;
    w = (s >= 32'(QUEUE_DEPTH)) ? s - 32'(QUEUE_DEPTH) : s;
    return w[QW-1:0];
  endfunction

  function automatic logic [EW-1:0] ewrap(input logic [31:0] s);
    logic [31:0] w;
    w = (s >= 32'(EVENT_DEPTH)) ? s - 32'(EVENT_DEPTH) : s;
    return w[EW-1:0];
  endfunction

  // blank result of one kind, marked last
  function automatic res_t blank_res(input logic [2:0] k);
    res_t r;
    r = '0;
    r.kind = k;
    r.last = 1'b1;
    return r;
  endfunction

  // memories
  slot_t slot_mem [QUEUE_DEPTH];
  ev_t   log_mem  [EVENT_DEPTH];
  slot_t slot_rd;
  ev_t   log_rd;

  state_t      state;
  req_t        cur;
  logic [QW-1:0] queue_head;
  logic [QW:0]   queue_count;
  logic [31:0]   ticket_counter;
  logic [31:0]   inflight_ticket;
  logic [EW-1:0] log_head;
  logic [EW:0]   log_count;
  logic [IW-1:0] idx;
  logic [QW-1:0] hit_pos;
  logic          found;
  logic [31:0]   tnew;
  logic [31:0]   log1_t, log2_t;
  logic [1:0]    log1_s, log2_s;
  logic          log1_v, log2_v;
  logic          slot_we;
  logic [QW-1:0] slot_wa;
  slot_t         slot_wd;
  logic [QW-1:0] slot_ra;
  logic [EW-1:0] log_ra;
  logic          log_we;
  ev_t           log_wd;
  logic [EW-1:0] log_wa;

  logic [QW-1:0] scan_pos;
  logic          size_ok;
  logic          report_log;
  logic [EW-1:0] ev_head_inc;
  logic [EW:0]   ev_sum;

  assign busy = (state != S_IDLE);
  assign size_ok = (req.msg_size != 16'd0) && (32'(req.msg_size) <= 32'(MAX_CMD_BYTES));
  assign report_log = (inflight_ticket != 32'd0) &&
                      (req.run_status == ST_DONE || req.run_status == ST_ERROR);
  assign scan_pos = qwrap(32'(queue_head) + 32'(idx));
  assign ev_head_inc = ewrap(32'(log_head) + 32'd1);

  // slot memory port
  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    slot_rd <= slot_mem[slot_ra];
  end

  // event log memory port
  always_ff @(posedge clk) begin
    if (log_we) log_mem[log_wa] <= log_wd;
    log_rd <= log_mem[log_ra];
  end

  // log write address, dropping the oldest event when full
  always_comb begin
    if (log_count >= EFULL) begin
      ev_sum = (EW+1)'(32'(ev_head_inc) + 32'(EVENT_DEPTH) - 32'd1);
    end else begin
      ev_sum = (EW+1)'(32'(log_head) + 32'(log_count));
    end
    log_wa = ewrap(32'(ev_sum));
  end

  // read addresses
  always_comb begin
    slot_ra = scan_pos;
    log_ra  = ewrap(32'(log_head) + 32'(idx));
    if (state == S_IDLE) begin
      slot_ra = queue_head;
      log_ra  = log_head;
    end
  end

  // memory writes
  always_comb begin
    slot_we = 1'b0;
    slot_wa = hit_pos;
    slot_wd = '{payload: cur.payload, size: cur.msg_size, ticket: tnew,
                key: cur.merge_key};
    log_we  = 1'b0;
    log_wd  = '{ticket: log1_t, st: log1_s};
    if (state == S_CHECK && cur.op == OP_PUSH && found) begin
      slot_we = 1'b1;
    end else if (state == S_CHECK && cur.op == OP_PUSH && queue_count < QFULL) begin
      slot_we = 1'b1;
      slot_wa = qwrap(32'(queue_head) + 32'(queue_count));
    end
    if (state == S_LOG1 && log1_v) begin
      log_we = 1'b1;
    end else if (state == S_LOG2 && log2_v) begin
      log_we = 1'b1;
      log_wd = '{ticket: log2_t, st: log2_s};
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      queue_head <= '0;
      queue_count <= '0;
      ticket_counter <= 32'd1;
      inflight_ticket <= '0;
      log_head <= '0;
      log_count <= '0;
      res_valid <= 1'b0;
      idx <= '0;
      found <= 1'b0;
      log1_v <= 1'b0;
      log2_v <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          res_valid <= 1'b0;
          log1_v <= start && req.op == OP_REPORT && report_log;
          log2_v <= 1'b0;
          found <= 1'b0;
          idx <= (start && req.op == OP_DRAIN) ? IW'(1) : '0;
          if (start) begin
            cur <= req;
            case (req.op)
              OP_PUSH: begin
                res <= blank_res(K_PUSH);
                if (!size_ok) begin
                  state <= S_REPLY;
                end else begin
                  tnew <= ticket_counter;
                  ticket_counter <= (ticket_counter == 32'hFFFF_FFFF) ? 32'd1
                                    : ticket_counter + 32'd1;
                  state <= (req.merge_key != 32'd0 && queue_count != '0) ? S_SCAN
                           : S_CHECK;
                end
              end
              OP_PENDING: begin
                res <= blank_res(K_PENDING);
                state <= (req.query_ticket != 32'd0 && queue_count != '0) ? S_SCAN
                         : S_REPLY;
              end
              OP_POP: begin
                if (queue_count == '0) begin
                  res <= blank_res(K_EMPTY);
                  state <= S_REPLY;
                end else begin
                  res <= blank_res(K_COMMAND);
                  state <= S_CHECK;
                end
              end
              OP_REPORT: begin
                res <= blank_res(K_ACK);
                if (report_log) begin
                  log1_t <= inflight_ticket;
                  log1_s <= req.run_status;
                  inflight_ticket <= '0;
                  state <= S_LOG1;
                end else begin
                  state <= S_REPLY;
                end
              end
              OP_DRAIN: begin
                if (log_count == '0) begin
                  res <= blank_res(K_NOEVENTS);
                  state <= S_REPLY;
                end else begin
                  res <= blank_res(K_EVENT);
                  state <= S_DRAIN;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        // one slot per cycle; slot_rd holds the slot issued last cycle
        S_SCAN: begin
          res_valid <= 1'b0;
          if (idx == '0) begin
            idx <= idx + 1'b1;
          end else if (cur.op == OP_PUSH && slot_rd.key == cur.merge_key) begin
            found <= 1'b1;
            hit_pos <= qwrap(32'(queue_head) + 32'(idx) - 32'd1);
            log1_v <= 1'b1;
            log1_t <= slot_rd.ticket;
            log1_s <= ST_DONE;
            state <= S_CHECK;
          end else if (cur.op == OP_PENDING && slot_rd.ticket == cur.query_ticket) begin
            res.is_pending <= 1'b1;
            state <= S_REPLY;
          end else if (idx == IW'(queue_count)) begin
            state <= (cur.op == OP_PUSH) ? S_CHECK : S_REPLY;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        // push commit, or pop with slot_rd at the head slot
        S_CHECK: begin
          res_valid <= 1'b0;
          if (cur.op == OP_PUSH) begin
            if (found) begin
              res.ticket_out <= tnew;
              state <= S_LOG1;
            end else if (queue_count < QFULL) begin
              res.ticket_out <= tnew;
              queue_count <= queue_count + 1'b1;
              state <= S_REPLY;
            end else begin
              state <= S_REPLY;
            end
          end else begin
            res.ticket_out <= slot_rd.ticket;
            res.payload_out <= slot_rd.payload;
            res.size_out <= slot_rd.size;
            res.serial_out <= cur.echo_serial + 32'sd1;
            queue_head <= qwrap(32'(queue_head) + 32'd1);
            queue_count <= queue_count - 1'b1;
            log1_v <= (inflight_ticket != '0);
            log1_t <= inflight_ticket;
            log1_s <= ST_DONE;
            log2_v <= (slot_rd.ticket != '0);
            log2_t <= slot_rd.ticket;
            log2_s <= ST_RECEIVED;
            inflight_ticket <= slot_rd.ticket;
            state <= S_LOG1;
          end
        end
        S_LOG1: begin
          res_valid <= 1'b0;
          if (log1_v) begin
            if (log_count >= EFULL) log_head <= ev_head_inc;
            else log_count <= log_count + 1'b1;
          end
          state <= S_LOG2;
        end
        S_LOG2: begin
          res_valid <= 1'b0;
          if (log2_v) begin
            if (log_count >= EFULL) log_head <= ev_head_inc;
            else log_count <= log_count + 1'b1;
          end
          state <= S_REPLY;
        end
        S_REPLY: begin
          res_valid <= 1'b1;
          state <= S_IDLE;
        end
        // event i is in log_rd while event i+1 is being read
        S_DRAIN: begin
          res.ticket_out <= log_rd.ticket;
          res.event_state <= log_rd.st;
          res.last <= ((EW+1)'(idx) == log_count);
          res_valid <= 1'b1;
          idx <= idx + 1'b1;
          if ((EW+1)'(idx) == log_count) begin
            log_head <= '0;
            log_count <= '0;
            state <= S_DOUT;
          end
        end
        S_DOUT: begin
          res_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: begin
          res_valid <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    queue_count <= QFULL) else $error("queue count overflow");
  a_log_bound: assert property (@(posedge clk) disable iff (rst)
    log_count <= EFULL) else $error("log count overflow");
  a_ticket_nz: assert property (@(posedge clk) disable iff (rst)
    ticket_counter != 32'd0) else $error("ticket counter hit zero");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |=> !res_valid) else $error("result from idle");
  a_res_state: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (state == S_IDLE || state == S_DRAIN || state == S_DOUT))
    else $error("result strobe in wrong state");

endmodule
`default_nettype wire
